// ===== rtl/mbs_pkg.sv =====
// Shared types, constants and helpers for the mailbox byte sender.
// No dependencies; imported by mbs_core and mailbox_byte_sender_with_drop.
`timescale 1ns / 1ps

package mbs_pkg;

  localparam int BYTES_PER_WORD = 3;
  localparam int NUM_SLOTS      = 3;

  localparam int FULL_POS  = 31;
  localparam int FLUSH_POS = 26;
  localparam int COUNT_POS = 24;

  localparam int POLL_W     = 24;
  localparam int ABORT_W    = 17;
  localparam int DEADLINE_W = 40;
  localparam int CNT_W      = 32;
  localparam int CFG_DATA_W = 40;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [1:0] {
    REG_POLL_TIMEOUT = 2'd0,
    REG_ABORT_LIMIT  = 2'd1,
    REG_DEADLINE     = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_DROPPED  = 2'd1,
    STAT_ABORTED  = 2'd2,
    STAT_DEADLINE = 2'd3
  } status_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       buffer_end;
    logic       mailbox_full;
  } in_item_t;

  typedef struct packed {
    logic             write_valid;
    logic [31:0]      mailbox_word;
    logic             busy_res;
    logic             byte_rejected;
    status_t          status;
    logic [CNT_W-1:0] sent_bytes;
    logic [CNT_W-1:0] dropped_bytes;
    logic [CNT_W-1:0] timeout_words;
    logic [CNT_W-1:0] worst_run;
  } out_item_t;

  typedef struct packed {
    logic [POLL_W-1:0]     poll_timeout_ticks;
    logic [ABORT_W-1:0]    abort_limit;
    logic [DEADLINE_W-1:0] deadline_ticks;
  } cfg_t;

  typedef logic [NUM_SLOTS-1:0][7:0] group_t;

  function automatic logic [CNT_W-1:0] sat_add32(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  // Only slots below the count land in the word; the rest stay zero.
  function automatic logic [31:0] build_word(input group_t bytes, input logic [1:0] count);
    logic [31:0] w;
    w = '0;
    w[FULL_POS] = 1'b1;
    w[FLUSH_POS] = 1'b1;
    w[COUNT_POS +: 2] = count;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (2'(i) < count) begin
        w[8*i +: 8] = bytes[i];
      end
    end
    return w;
  endfunction

endpackage

// ===== rtl/mbs_core.sv =====
// Per-word state and counters of the mailbox byte sender: one item per step.
// Depends on mbs_pkg. Result is combinational; the caller registers it.
`timescale 1ns / 1ps

module mbs_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  mbs_pkg::in_item_t item,
  input  mbs_pkg::cfg_t     cfg,
  output mbs_pkg::out_item_t result
);
  import mbs_pkg::*;

  group_t                group_bytes, group_bytes_next;
  logic [1:0]            group_count, group_count_next;
  logic                  word_waiting, word_waiting_next;
  logic [POLL_W-1:0]     wait_ticks, wait_ticks_next;
  logic [DEADLINE_W-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [CNT_W-1:0]      run_length, run_length_next;
  logic [CNT_W-1:0]      worst_run_reg, worst_run_reg_next;
  logic [CNT_W-1:0]      sent_count, sent_count_next;
  logic [CNT_W-1:0]      drop_count, drop_count_next;
  logic [CNT_W-1:0]      timeout_count, timeout_count_next;
  logic                  abort_flag, abort_flag_next;
  logic                  deadline_flag, deadline_flag_next;

  logic        is_tick;
  logic        wrote;
  logic        rejected;
  logic        finish;
  logic [31:0] word;
  status_t     status;

  always_comb begin
    is_tick             = (item.kind == KIND_TICK);
    group_bytes_next    = group_bytes;
    group_count_next    = group_count;
    word_waiting_next   = word_waiting;
    wait_ticks_next     = wait_ticks;
    elapsed_ticks_next  = elapsed_ticks;
    run_length_next     = run_length;
    worst_run_reg_next  = worst_run_reg;
    sent_count_next     = sent_count;
    drop_count_next     = drop_count;
    timeout_count_next  = timeout_count;
    abort_flag_next     = abort_flag;
    deadline_flag_next  = deadline_flag;
    wrote               = 1'b0;
    rejected            = 1'b0;
    finish              = 1'b0;
    word                = '0;

    if (is_tick) begin
      if (elapsed_ticks != {DEADLINE_W{1'b1}}) begin
        elapsed_ticks_next = elapsed_ticks + 1'b1;
      end
    end else if (word_waiting || abort_flag || deadline_flag) begin
      rejected = 1'b1;
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (2'(i) == group_count) begin
          group_bytes_next[i] = item.data_byte;
        end
      end
      group_count_next = group_count + 2'd1;
      if (group_count_next >= 2'(BYTES_PER_WORD) || item.buffer_end) begin
        word_waiting_next = 1'b1;
        wait_ticks_next   = '0;
      end
    end

    // FULL is sampled on every step a word waits, including the closing one
    if (word_waiting_next) begin
      if (!item.mailbox_full) begin
        wrote           = 1'b1;
        word            = build_word(group_bytes_next, group_count_next);
        run_length_next = '0;
        sent_count_next = sat_add32(sent_count, CNT_W'(group_count_next));
        finish          = 1'b1;
      end else if (is_tick) begin
        if (wait_ticks >= cfg.poll_timeout_ticks) begin
          drop_count_next    = sat_add32(drop_count, CNT_W'(group_count_next));
          timeout_count_next = sat_add32(timeout_count, CNT_W'(1));
          run_length_next    = sat_add32(run_length, CNT_W'(1));
          if (run_length_next > worst_run_reg) begin
            worst_run_reg_next = run_length_next;
          end
          if (cfg.abort_limit != '0 && run_length_next >= CNT_W'(cfg.abort_limit)) begin
            abort_flag_next = 1'b1;
          end
          finish = 1'b1;
        end else begin
          wait_ticks_next = wait_ticks + 1'b1;
        end
      end
    end

    // stop check at word end; abort takes precedence over the deadline
    if (finish) begin
      group_count_next  = '0;
      word_waiting_next = 1'b0;
      wait_ticks_next   = '0;
      if (!abort_flag_next && cfg.deadline_ticks != '0 &&
          elapsed_ticks_next >= cfg.deadline_ticks) begin
        deadline_flag_next = 1'b1;
      end
    end

    priority if (abort_flag_next) begin
      status = STAT_ABORTED;
    end else if (deadline_flag_next) begin
      status = STAT_DEADLINE;
    end else if (drop_count_next != '0) begin
      status = STAT_DROPPED;
    end else begin
      status = STAT_OK;
    end

    result.write_valid   = wrote;
    result.mailbox_word  = word;
    result.busy_res      = word_waiting_next;
    result.byte_rejected = rejected;
    result.status        = status;
    result.sent_bytes    = sent_count_next;
    result.dropped_bytes = drop_count_next;
    result.timeout_words = timeout_count_next;
    result.worst_run     = worst_run_reg_next;
  end

  always_ff @(posedge clk) begin
    if (step) begin
      group_bytes <= group_bytes_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_count   <= '0;
      word_waiting  <= 1'b0;
      wait_ticks    <= '0;
      elapsed_ticks <= '0;
      run_length    <= '0;
      worst_run_reg <= '0;
      sent_count    <= '0;
      drop_count    <= '0;
      timeout_count <= '0;
      abort_flag    <= 1'b0;
      deadline_flag <= 1'b0;
    end else if (step) begin
      group_count   <= group_count_next;
      word_waiting  <= word_waiting_next;
      wait_ticks    <= wait_ticks_next;
      elapsed_ticks <= elapsed_ticks_next;
      run_length    <= run_length_next;
      worst_run_reg <= worst_run_reg_next;
      sent_count    <= sent_count_next;
      drop_count    <= drop_count_next;
      timeout_count <= timeout_count_next;
      abort_flag    <= abort_flag_next;
      deadline_flag <= deadline_flag_next;
    end
  end

endmodule

// ===== rtl/mailbox_byte_sender_with_drop.sv =====
// Mailbox byte sender with timeout drop: top level with input/output registers and config.
// Depends on mbs_pkg and mbs_core.
`timescale 1ns / 1ps

// Accepts one word per cycle while in_stall is low (a data byte or a time tick, with the
// sampled mailbox FULL bit) and returns exactly one result word per input, held first in the
// input register and then in the result register. Bytes are packed up to three per mailbox
// word; the result carries the word written this step, if any, and the running status and
// saturating counters. Throughput is one word per cycle while the output is not stalled, as
// mbs_core updates its state on every step. Configuration writes are always ready and must
// only be issued while the block is idle.
module mailbox_byte_sender_with_drop (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mbs_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mbs_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [mbs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mbs_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_q_valid;
  logic      advance;
  logic      step;
  out_item_t result;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign step      = in_q_valid && advance;
  assign in_stall  = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_timeout_ticks <= POLL_W'(1000);
      cfg.abort_limit        <= '0;
      cfg.deadline_ticks     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_POLL_TIMEOUT: cfg.poll_timeout_ticks <= cfg_data[POLL_W-1:0];
        REG_ABORT_LIMIT:  cfg.abort_limit        <= cfg_data[ABORT_W-1:0];
        REG_DEADLINE:     cfg.deadline_ticks     <= cfg_data[DEADLINE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else begin
      in_q_valid <= (in_valid && !in_stall) || (in_q_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  mbs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_q),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

endmodule
